@@ rtl/core/mha_pkg.sv @@
// mha_pkg: shared types, widths and the micro-rotation angle table for
// the magnetic heading CORDIC. No dependencies.
`timescale 1ns / 1ps

package mha_pkg;

  // Datapath widths. |x|,|y| stay below 2^25 after gain; z stays within
  // about -100..280 degrees in 2^-16 degree units.
  localparam int XW = 27;
  localparam int ZW = 26;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  localparam int ANGLE_TABLE_LEN   = 24;
  localparam int CORDIC_ITERATIONS = 16;

  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);
  localparam logic signed [ZW-1:0] DEG360_Q16 = ZW'(23592960);
  localparam int HEADING_WRAP = 46080;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // atan(2^-i) in degrees, Q16, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/mha_prerot.sv @@
// mha_prerot: input stage. Folds the left half-plane onto the right,
// scales by 256 and flags the zero vector. Depends on mha_pkg.
`timescale 1ns / 1ps

module mha_prerot (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [mha_pkg::IN_W-1:0]    mag_x,
  input  logic signed [mha_pkg::IN_W-1:0]    mag_y,
  output logic                               valid,
  output mha_pkg::cordic_t                   data
);
  import mha_pkg::*;

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic                 neg;
  cordic_t              data_next;

  assign xe  = XW'(mag_x);
  assign ye  = XW'(mag_y);
  assign neg = mag_x[IN_W-1];

  always_comb begin
    data_next.x    = (neg ? -xe : xe) <<< 8;
    data_next.y    = (neg ? -ye : ye) <<< 8;
    data_next.z    = neg ? DEG180_Q16 : '0;
    data_next.zero = (mag_x == '0) && (mag_y == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

@@ rtl/core/mha_cordic_stage.sv @@
// mha_cordic_stage: one vectoring micro-rotation with a fixed shift,
// registered. Depends on mha_pkg.
`timescale 1ns / 1ps

module mha_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  mha_pkg::cordic_t in_data,
  output logic             valid,
  output mha_pkg::cordic_t data
);
  import mha_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_q16(5'(STAGE));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_t              data_next;

  assign xs = in_data.x >>> STAGE;
  assign ys = in_data.y >>> STAGE;

  always_comb begin
    data_next.zero = in_data.zero;
    if (!in_data.y[XW-1]) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ANGLE;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

@@ rtl/core/mha_finalize.sv @@
// mha_finalize: output stage. Maps the angle into [0, 360), rounds to
// 1/128 degree and wraps 360.0 to 0. Depends on mha_pkg.
`timescale 1ns / 1ps

module mha_finalize (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  mha_pkg::cordic_t            in_data,
  output logic                        out_valid,
  output logic [mha_pkg::OUT_W-1:0]   heading
);
  import mha_pkg::*;

  localparam int HW = ZW - 8;

  logic signed [ZW-1:0] zp;
  logic [ZW:0]          zr;
  logic [HW-1:0]        hr;
  logic [HW-1:0]        hw;
  logic [OUT_W-1:0]     heading_next;

  always_comb begin
    zp = in_data.z[ZW-1] ? (in_data.z + DEG360_Q16) : in_data.z;
    zr = {1'b0, zp} + (ZW+1)'(256);
    hr = zr[ZW:9];
    hw = (hr >= HW'(HEADING_WRAP)) ? (hr - HW'(HEADING_WRAP)) : hr;
    heading_next = in_data.zero ? '0 : hw[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= heading_next;
    end
  end

endmodule

@@ rtl/core/magnetic_heading_atan2.sv @@
// magnetic_heading_atan2: top level of the pipelined CORDIC compass heading.
// Depends on mha_pkg, mha_prerot, mha_cordic_stage, mha_finalize.
`timescale 1ns / 1ps

// Compass heading atan2(mag_y, mag_x) in 1/128 degree units, 0..46079,
// from signed 16-bit horizontal magnetometer samples. A fully pipelined
// vectoring CORDIC: one input stage (half-plane fold), one register
// stage per micro-rotation, one output stage (wrap and round). One
// transfer is taken every cycle while in_stall is low. Each stage holds
// its item until the next stage frees, so empty stages fill under
// output stall and in_stall rises only when every stage holds an item
// and the output is stalled. Input (0, 0) gives 0; a rounded 360.0
// degrees gives 0. No state is kept between samples and there is
// nothing to configure.
module magnetic_heading_atan2 #(
  parameter int CORDIC_ITERATIONS = mha_pkg::CORDIC_ITERATIONS
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mha_pkg::IN_W-1:0]  mag_x,
  input  logic signed [mha_pkg::IN_W-1:0]  mag_y,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mha_pkg::OUT_W-1:0]        heading
);
  import mha_pkg::*;

  // Table holds 24 angles; more iterations act as 24.
  localparam int N = (CORDIC_ITERATIONS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN
                                                           : CORDIC_ITERATIONS;

  // Index 0 is the input stage, 1..N the micro-rotations.
  logic    stg_v [0:N];
  cordic_t stg_d [0:N];
  // en[k] loads stage k; en[N+1] loads the output register.
  logic [N+1:0] en;

  assign en[N+1] = !out_valid || !out_stall;

  genvar k;
  generate
    for (k = 0; k <= N; k++) begin : g_en
      // A stage loads when empty or when its content moves on.
      assign en[k] = !stg_v[k] || en[k+1];
    end
  endgenerate

  assign in_stall = !en[0];

  mha_prerot u_prerot (
    .clk      (clk),
    .rst      (rst),
    .en       (en[0]),
    .in_valid (in_valid),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .valid    (stg_v[0]),
    .data     (stg_d[0])
  );

  generate
    for (k = 1; k <= N; k++) begin : g_stage
      mha_cordic_stage #(
        .STAGE (k - 1)
      ) u_stage (
        .clk      (clk),
        .rst      (rst),
        .en       (en[k]),
        .in_valid (stg_v[k-1]),
        .in_data  (stg_d[k-1]),
        .valid    (stg_v[k]),
        .data     (stg_d[k])
      );
    end
  endgenerate

  mha_finalize u_finalize (
    .clk       (clk),
    .rst       (rst),
    .en        (en[N+1]),
    .in_valid  (stg_v[N]),
    .in_data   (stg_d[N]),
    .out_valid (out_valid),
    .heading   (heading)
  );

  // Input backpressure only ever comes from a stalled, full output.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without output backpressure");

  // An accepted transfer lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> stg_v[0])
    else $error("accepted transfer lost at input stage");

  // The zero vector is flagged on entry.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mag_x == '0 && mag_y == '0) |=> stg_d[0].zero)
    else $error("zero vector not flagged");

  // Heading always wraps below 360 degrees.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading < OUT_W'(HEADING_WRAP)))
    else $error("heading out of range");

endmodule
